/* sv/momsgd_pkg.sv */
package momsgd_pkg;

	localparam int NUM_PARAMS = 4096;
	localparam int IDX_W      = $clog2(NUM_PARAMS);
	localparam int DATA_W     = 32;
	localparam int COEF_W     = 24;
	localparam int PROD_W     = 58;
	localparam int FRAC_SHIFT = 23;
	localparam int CFG_IDX_W  = 2;

	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic signed [DATA_W-1:0]  data_t;
	typedef logic [COEF_W-1:0]         coef_t;
	typedef logic [COEF_W:0]           coef_ext_t;
	typedef logic signed [PROD_W-1:0]  prod_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE     = 2'd0,
		REG_LR       = 2'd1,
		REG_MOMENTUM = 2'd2,
		REG_DECAY    = 2'd3
	} cfg_reg_t;

	localparam logic  MODE_PLAIN    = 1'b0;
	localparam logic  MODE_NESTEROV = 1'b1;

	localparam coef_t LR_RESET       = COEF_W'(83886);
	localparam coef_t MOMENTUM_RESET = COEF_W'(7549747);
	localparam coef_t DECAY_RESET    = COEF_W'(0);

	localparam coef_ext_t ONE_Q23  = coef_ext_t'(1) << FRAC_SHIFT;
	localparam prod_t     HALF_LSB = prod_t'(1) <<< (FRAC_SHIFT - 1);

	// sign-extend a data word to the product width
	function automatic prod_t ext(input data_t a);
		return {{(PROD_W-DATA_W){a[DATA_W-1]}}, a};
	endfunction

	// clamp to the signed data range
	function automatic data_t sat32(input prod_t x);
		if (&x[PROD_W-1:DATA_W-1] || ~|x[PROD_W-1:DATA_W-1]) begin
			return x[DATA_W-1:0];
		end
		return x[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
	endfunction

	// signed value times unsigned coefficient, exact
	function automatic prod_t mulq(input data_t a, input coef_ext_t c);
		prod_t cs;
		cs = $signed({{(PROD_W-COEF_W-1){1'b0}}, c});
		return ext(a) * cs;
	endfunction

	// round half up to the data grid, then clamp
	function automatic data_t qrnd(input prod_t p);
		prod_t t;
		t = (p + HALF_LSB) >>> FRAC_SHIFT;
		return sat32(t);
	endfunction

endpackage

/* sv/momsgd_if.sv */
interface momsgd_req_if import momsgd_pkg::*; ();
	logic  valid;
	logic  ready;
	idx_t  param_index;
	data_t weight_in;
	data_t gradient_in;

	modport source (output valid, param_index, weight_in, gradient_in, input ready);
	modport sink   (input valid, param_index, weight_in, gradient_in, output ready);
endinterface

interface momsgd_rsp_if import momsgd_pkg::*; ();
	logic  valid;
	logic  ready;
	data_t weight_out;
	data_t velocity_out;

	modport source (output valid, weight_out, velocity_out, input ready);
	modport sink   (input valid, weight_out, velocity_out, output ready);
endinterface

/* sv/momentum_sgd_weight_update_core.sv */
// Momentum SGD weight update (plain or Nesterov). Each request carries a parameter index, its
// weight and its raw gradient; the core reads the velocity of that parameter from an on-chip
// memory, forms v' = momentum*v - lr*(g + decay*w), writes v' back and returns the new weight
// and v' (signed Q8.24, saturated). One request is taken per clock unless the result side
// stalls or an index conflict holds it. The rate is set by the read-modify-write loop on the
// velocity memory: a request whose index matches one still in the first four stages waits
// until that one has written its velocity back; behind a request with its index it waits
// while that one is in stages one to three, longer while the result side stalls. After reset
// a clearing pass writes zero to all 4096 velocity entries, one per cycle, and no request is
// taken until it is over; configuration writes are taken at any time and should only be
// issued while no request is in flight.
module momentum_sgd_weight_update_core import momsgd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  coef_t                cfg_data,
	momsgd_req_if.sink           req,
	momsgd_rsp_if.source         rsp
);

	// configuration registers
	logic  mode_q;
	coef_t lr_q;
	coef_t mf_q;
	coef_t wd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			lr_q   <= LR_RESET;
			mf_q   <= MOMENTUM_RESET;
			wd_q   <= DECAY_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_MODE:     mode_q <= cfg_data[0];
				REG_LR:       lr_q   <= cfg_data;
				REG_MOMENTUM: mf_q   <= cfg_data;
				REG_DECAY:    wd_q   <= cfg_data;
				default:      ;
			endcase
		end
	end

	// clearing pass: the top bit of the counter marks the end of the sweep
	logic [IDX_W:0] clr_cnt_q;
	logic           clr_done;

	assign clr_done = clr_cnt_q[IDX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (!clr_done) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// pipeline valids and advance chain (each stage takes when empty or draining)
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, rsp_vld_q;
	logic take1, take2, take3, take4, take5, take6, take_o;

	assign take_o = !rsp_vld_q || rsp.ready;
	assign take6  = !vld_s6 || take_o;
	assign take5  = !vld_s5 || take6;
	assign take4  = !vld_s4 || take5;
	assign take3  = !vld_s3 || take4;
	assign take2  = !vld_s2 || take3;
	assign take1  = !vld_s1 || take2;

	// payload registers
	idx_t  idx_s1, idx_s2, idx_s3, idx_s4;
	data_t w_s1, w_s2, w_s3, w_s4, w_s5;
	data_t g_s1, g_s2;
	data_t v_s2;
	prod_t dprod_s2;
	data_t geff_s3;
	prod_t mprod_s3;
	prod_t lprod_s4;
	data_t mv_s4;
	data_t vn_s5, w1_s5;
	prod_t nprod_s6;
	data_t wplain_s6, w1_s6, vn_s6;
	data_t weight_q, velocity_q;

	// interlock: hold a request whose index still has a velocity write pending
	logic conflict;
	logic accept;

	assign conflict = (vld_s1 && idx_s1 == req.param_index) ||
	                  (vld_s2 && idx_s2 == req.param_index) ||
	                  (vld_s3 && idx_s3 == req.param_index) ||
	                  (vld_s4 && idx_s4 == req.param_index && !take5);
	assign req.ready = clr_done && take1 && !conflict;
	assign accept    = req.valid && req.ready;

	// velocity memory: one write port, one registered read port with write bypass
	data_t mem [NUM_PARAMS];
	data_t rd_q;
	logic  mem_we;
	idx_t  mem_waddr;
	data_t mem_wdata;
	data_t vn_s4;
	data_t w1_s4;

	assign vn_s4     = sat32(ext(mv_s4) - ext(qrnd(lprod_s4)));
	assign w1_s4     = sat32(ext(w_s4) - ext(mv_s4));
	assign mem_we    = !clr_done || (vld_s4 && take5);
	assign mem_waddr = clr_done ? idx_s4 : clr_cnt_q[IDX_W-1:0];
	assign mem_wdata = clr_done ? vn_s4 : '0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			rd_q <= (mem_we && mem_waddr == req.param_index) ? mem_wdata : mem[req.param_index];
		end
	end

	// control: advance valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (take1)  vld_s1    <= accept;
			if (take2)  vld_s2    <= vld_s1;
			if (take3)  vld_s3    <= vld_s2;
			if (take4)  vld_s4    <= vld_s3;
			if (take5)  vld_s5    <= vld_s4;
			if (take6)  vld_s6    <= vld_s5;
			if (take_o) rsp_vld_q <= vld_s6;
		end
	end

	coef_ext_t nest_coef;
	assign nest_coef = coef_ext_t'(mf_q) + ONE_Q23;

	// datapath: at most one multiplier per stage, rounding and clamping after each register
	always_ff @(posedge clk) begin
		// capture request
		if (accept) begin
			idx_s1 <= req.param_index;
			w_s1   <= req.weight_in;
			g_s1   <= req.gradient_in;
		end
		// decay product; velocity read data lands here
		if (take2 && vld_s1) begin
			idx_s2   <= idx_s1;
			w_s2     <= w_s1;
			g_s2     <= g_s1;
			v_s2     <= rd_q;
			dprod_s2 <= mulq(w_s1, {1'b0, wd_q});
		end
		// effective gradient and momentum product
		if (take3 && vld_s2) begin
			idx_s3   <= idx_s2;
			w_s3     <= w_s2;
			geff_s3  <= sat32(ext(g_s2) + ext(qrnd(dprod_s2)));
			mprod_s3 <= mulq(v_s2, {1'b0, mf_q});
		end
		// learning-rate product
		if (take4 && vld_s3) begin
			idx_s4   <= idx_s3;
			w_s4     <= w_s3;
			lprod_s4 <= mulq(geff_s3, {1'b0, lr_q});
			mv_s4    <= qrnd(mprod_s3);
		end
		// new velocity, written back on this advance
		if (take5 && vld_s4) begin
			w_s5  <= w_s4;
			vn_s5 <= vn_s4;
			w1_s5 <= w1_s4;
		end
		// Nesterov product and plain weight
		if (take6 && vld_s5) begin
			nprod_s6  <= mulq(vn_s5, nest_coef);
			wplain_s6 <= sat32(ext(w_s5) + ext(vn_s5));
			w1_s6     <= w1_s5;
			vn_s6     <= vn_s5;
		end
		// output register
		if (take_o && vld_s6) begin
			weight_q   <= (mode_q == MODE_NESTEROV) ?
			              sat32(ext(w1_s6) + ext(qrnd(nprod_s6))) : wplain_s6;
			velocity_q <= vn_s6;
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.weight_out   = weight_q;
	assign rsp.velocity_out = velocity_q;

	// no request is taken before the clearing pass is over
	a_no_req_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_done |-> !req.ready)
		else $error("request taken during velocity clearing pass");

	// a taken request never shares its index with one that has not yet written back
	a_no_raw_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !(vld_s2 && vld_s1 && idx_s2 == idx_s1) &&
		           !(vld_s3 && vld_s1 && idx_s3 == idx_s1))
		else $error("read of a velocity entry with a pending write");

	// a result held in the output register survives a stall
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && !rsp.ready |=> rsp_vld_q && $stable(weight_q) && $stable(velocity_q))
		else $error("result dropped or changed while stalled");

endmodule

/* tb/momsgd_update_checker.sv */
`timescale 1ns / 100ps

module momsgd_update_checker import momsgd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  coef_t                cfg_data,
	momsgd_req_if                req,
	momsgd_rsp_if                rsp,
	output int                   n_errors,
	output int                   n_pending
);

	localparam longint SAT_MAX = 64'sd2147483647;
	localparam longint SAT_MIN = -64'sd2147483648;

	typedef struct {
		data_t weight;
		data_t velocity;
	} update_t;

	logic    mode_q;
	coef_t   lr_q;
	coef_t   mom_q;
	coef_t   decay_q;
	data_t   velocity_mirror [NUM_PARAMS];
	update_t expected_updates [$];

	function automatic longint clamp32(input longint x);
		if (x > SAT_MAX) begin
			return SAT_MAX;
		end
		if (x < SAT_MIN) begin
			return SAT_MIN;
		end
		return x;
	endfunction

	// Q8.24 value times unsigned Q.23 coefficient, round half up, clamp
	function automatic longint scale_round(input longint value, input longint coef);
		longint p;
		p = value * coef + (longint'(1) <<< (FRAC_SHIFT - 1));
		return clamp32(p >>> FRAC_SHIFT);
	endfunction

	task automatic predict_update(input idx_t idx, input data_t w_in, input data_t g_in);
		longint  w, g, v, g_eff, mv, lg, v_new, w_new;
		update_t e;
		w = longint'(w_in);
		g = longint'(g_in);
		v = longint'(velocity_mirror[idx]);
		g_eff = clamp32(g + scale_round(w, longint'(decay_q)));
		mv    = scale_round(v, longint'(mom_q));
		lg    = scale_round(g_eff, longint'(lr_q));
		v_new = clamp32(mv - lg);
		if (mode_q == MODE_PLAIN) begin
			w_new = clamp32(w + v_new);
		end else begin
			w_new = clamp32(clamp32(w - mv)
				+ scale_round(v_new, (longint'(1) <<< FRAC_SHIFT) + longint'(mom_q)));
		end
		velocity_mirror[idx] = data_t'(v_new);
		e.weight   = data_t'(w_new);
		e.velocity = data_t'(v_new);
		expected_updates.push_back(e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		update_t e;
		if (!arst_n) begin
			mode_q  <= MODE_PLAIN;
			lr_q    <= LR_RESET;
			mom_q   <= MOMENTUM_RESET;
			decay_q <= DECAY_RESET;
			foreach (velocity_mirror[i]) velocity_mirror[i] = '0;
			expected_updates.delete();
			n_errors  <= 0;
			n_pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_updates.size() == 0) begin
					$display("%0t: unexpected result weight_out %0d velocity_out %0d",
						$time, rsp.weight_out, rsp.velocity_out);
					n_errors <= n_errors + 1;
				end else begin
					e = expected_updates.pop_front();
					if (rsp.weight_out !== e.weight || rsp.velocity_out !== e.velocity) begin
						if (rsp.weight_out !== e.weight) begin
							$display("%0t: weight_out expected %0d actual %0d",
								$time, e.weight, rsp.weight_out);
						end
						if (rsp.velocity_out !== e.velocity) begin
							$display("%0t: velocity_out expected %0d actual %0d",
								$time, e.velocity, rsp.velocity_out);
						end
						n_errors <= n_errors + 1;
					end
				end
			end
			if (req.valid && req.ready) begin
				predict_update(req.param_index, req.weight_in, req.gradient_in);
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_MODE:     mode_q  <= cfg_data[0];
					REG_LR:       lr_q    <= cfg_data;
					REG_MOMENTUM: mom_q   <= cfg_data;
					REG_DECAY:    decay_q <= cfg_data;
					default: ;
				endcase
			end
			n_pending <= expected_updates.size();
		end
	end

endmodule

/* tb/tb_momentum_sgd_weight_update_core.sv */
`timescale 1ns / 100ps

module tb_momentum_sgd_weight_update_core;
	import momsgd_pkg::*;

	// No request is taken during the clearing pass after reset, which writes all 4096 entries;
	// allow for that pass several times over before calling the run hung.
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASE_ITEMS    = 150;
	localparam int DRAIN_CYCLES   = 12;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	coef_t                cfg_data;
	int                   n_errors;
	int                   n_pending;
	int                   idle_cycles = 0;
	int                   burst_left = 0;
	int                   stall_cycle = 0;

	momsgd_req_if req_ch ();
	momsgd_rsp_if rsp_ch ();

	momentum_sgd_weight_update_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	momsgd_update_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.n_errors  (n_errors),
		.n_pending (n_pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result side: cycle through four stall styles in turn so that
	// back-pressure lands on every stage of the pipeline, with whole stretches
	// of no stall at all (style 0).
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			case ((stall_cycle / 256) % 4)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
				2: rsp_ch.ready <= ((stall_cycle % 7) < 5);
				default: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
			endcase
		end
		stall_cycle <= stall_cycle + 1;
	end

	// Stop the run when neither channel moves for too long.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Hold one request on the channel until it is taken. Call at a rising edge;
	// returns at the edge that accepted it, leaving valid high for a follow-on.
	task automatic push_request(input idx_t idx, input data_t w, input data_t g);
		req_ch.valid       <= 1'b1;
		req_ch.param_index <= idx;
		req_ch.weight_in   <= w;
		req_ch.gradient_in <= g;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// Sender pacing: bursts of random length, random gaps between them,
	// and now and then no gap so that bursts run into one another.
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
	endtask

	// Drop valid, wait until every result is back, then let the pipeline settle.
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (n_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all four registers on consecutive edges once the core is idle.
	// Put random junk above bit 0 of the mode write: only bit 0 must count.
	task automatic write_config(input logic nest, input coef_t lr, input coef_t mom,
		input coef_t decay);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_MODE;
		cfg_data  <= {(COEF_W-1)'($urandom), nest};
		@(posedge clk);
		cfg_index <= REG_LR;
		cfg_data  <= lr;
		@(posedge clk);
		cfg_index <= REG_MOMENTUM;
		cfg_data  <= mom;
		@(posedge clk);
		cfg_index <= REG_DECAY;
		cfg_data  <= decay;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Favor a handful of entries so that the same index comes back within the
	// read-modify-write window; also hit the first and last entry.
	function automatic idx_t pick_index();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			return idx_t'($urandom_range(0, 3));
		end
		if (sel == 4) begin
			return ($urandom_range(0, 1) == 0) ? idx_t'(0) : idx_t'(NUM_PARAMS - 1);
		end
		return idx_t'($urandom);
	endfunction

	// Mostly weights and gradients of realistic size, plus full-range words,
	// extremes, and large values that drive the sums into saturation.
	function automatic data_t pick_word();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5) begin
			return data_t'(int'($urandom_range(0, 33554432)) - 16777216);
		end
		if (sel < 7) begin
			return data_t'($urandom);
		end
		if (sel == 7) begin
			case ($urandom_range(0, 4))
				0: return 32'sh80000000;
				1: return 32'sh7FFFFFFF;
				2: return 32'sh0;
				3: return -32'sd1;
				default: return 32'sd1;
			endcase
		end
		return data_t'($signed($urandom) >>> $urandom_range(0, 8));
	endfunction

	function automatic coef_t pick_coef();
		return coef_t'($urandom_range(0, 24'hFFFFFF));
	endfunction

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = REG_MODE;
		cfg_data           = '0;
		req_ch.valid       = 1'b0;
		req_ch.param_index = '0;
		req_ch.weight_in   = '0;
		req_ch.gradient_in = '0;
		rsp_ch.ready       = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings (plain mode): zero, extremes of both signs,
		// the same index twice in a row, and mixed signs.
		push_request(idx_t'(0), 32'sh0, 32'sh0);
		push_request(idx_t'(NUM_PARAMS - 1), 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		push_request(idx_t'(NUM_PARAMS - 1), 32'sh80000000, 32'sh80000000);
		push_request(idx_t'(1), 32'sh80000000, 32'sh7FFFFFFF);
		push_request(idx_t'(1), 32'sh7FFFFFFF, 32'sh80000000);
		push_request(idx_t'(2), 32'sd1, -32'sd1);

		// Directed, Nesterov with every coefficient at its maximum: saturate
		// every intermediate sum.
		write_config(MODE_NESTEROV, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		push_request(idx_t'(NUM_PARAMS - 1), 32'sh7FFFFFFF, 32'sh80000000);
		push_request(idx_t'(NUM_PARAMS - 1), 32'sh80000000, 32'sh7FFFFFFF);
		push_request(idx_t'(0), 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		push_request(idx_t'(0), 32'sh80000000, 32'sh80000000);
		push_request(idx_t'(3), -32'sd1, 32'sd1);

		// Directed, coefficients of one half: products land exactly on the
		// rounding tie for both signs.
		write_config(MODE_PLAIN, 24'h400000, 24'h400000, 24'h400000);
		push_request(idx_t'(4), 32'sd0, 32'sd1);
		push_request(idx_t'(5), 32'sd0, -32'sd1);
		push_request(idx_t'(6), 32'sd1, 32'sd3);
		push_request(idx_t'(6), -32'sd1, -32'sd3);
		push_request(idx_t'(7), -32'sd3, 32'sd0);

		// Directed, all coefficients zero: velocity collapses, weight passes.
		write_config(MODE_PLAIN, 24'h0, 24'h0, 24'h0);
		push_request(idx_t'(NUM_PARAMS - 1), 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		push_request(idx_t'(1), 32'sh80000000, 32'sh80000000);
		push_request(idx_t'(2), 32'sh12345678, -32'sh0EDCBA98);

		// Random phases, each with its own setting.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_config(MODE_PLAIN, coef_t'($urandom_range(0, 1 << 20)),
					MOMENTUM_RESET, coef_t'($urandom_range(0, 1 << 16)));
				1: write_config(MODE_NESTEROV, coef_t'($urandom_range(0, 1 << 20)),
					pick_coef(), coef_t'($urandom_range(0, 1 << 16)));
				2: write_config(MODE_NESTEROV, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
				3: write_config(MODE_PLAIN, 24'h0, 24'h0, 24'h0);
				4: write_config(logic'($urandom_range(0, 1)), pick_coef(), pick_coef(),
					pick_coef());
				default: write_config(MODE_NESTEROV, 24'h800000, pick_coef(), 24'h0);
			endcase
			repeat (PHASE_ITEMS) begin
				pace();
				push_request(pick_index(), pick_word(), pick_word());
			end
		end

		drain();
		if (n_errors == 0 && n_pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
